/* src/mfr_pkg.sv */
// ----------------------------------------------------------------------------
// mfr_pkg
// Types, constants and CRC helpers for the frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // Parser phase, one per header field plus payload and CRC bytes
  typedef enum logic [3:0] {
    PH_START,
    PH_LEN,
    PH_INCOMPAT,
    PH_COMPAT,
    PH_SEQ,
    PH_SYS,
    PH_COMP,
    PH_ID0,
    PH_ID1,
    PH_ID2,
    PH_PAYLOAD,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  // Reported message kind
  typedef enum logic [1:0] {
    KIND_HEARTBEAT = 2'd0,
    KIND_GLOBAL_POS = 2'd1,
    KIND_CMD_ACK = 2'd2,
    KIND_OTHER = 2'd3
  } msg_kind_t;

  localparam logic [7:0] START_V1 = 8'hFE;
  localparam logic [7:0] START_V2 = 8'hFD;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  localparam logic [23:0] ID_HEARTBEAT = 24'd0;
  localparam logic [23:0] ID_GLOBAL_POS = 24'd33;
  localparam logic [23:0] ID_CMD_LONG = 24'd76;
  localparam logic [23:0] ID_CMD_ACK = 24'd77;

  localparam logic [7:0] EXTRA_HEARTBEAT = 8'd50;
  localparam logic [7:0] EXTRA_GLOBAL_POS = 8'd104;
  localparam logic [7:0] EXTRA_CMD_LONG = 8'd152;
  localparam logic [7:0] EXTRA_CMD_ACK = 8'd143;

  // Only payload bytes 0..19 are ever decoded; keep that window
  localparam int WIN_BYTES = 20;
  localparam int WIN_IDX_W = $clog2(WIN_BYTES);

  // One X.25 (MCRF4XX) CRC-16 step over a byte
  function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] v);
    logic [7:0] t;
    t = v ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

  // Per-message extra byte folded in at the end of the frame
  function automatic logic [7:0] extra_byte(input logic [23:0] id);
    logic [7:0] e;
    case (id)
      ID_HEARTBEAT:  e = EXTRA_HEARTBEAT;
      ID_GLOBAL_POS: e = EXTRA_GLOBAL_POS;
      ID_CMD_LONG:   e = EXTRA_CMD_LONG;
      ID_CMD_ACK:    e = EXTRA_CMD_ACK;
      default:       e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

/* src/mavlink_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// mavlink_frame_receiver_unit
// Byte-wide v1/v2 frame parser with CRC check and field decode.
// ----------------------------------------------------------------------------
// Result: a frame with a good CRC is registered on its accepted high CRC byte and shows in the cycle after it.
// Throughput: one byte per cycle while in_stall is low; the CRC step and phase update are one
//   combinational stage between the parser registers and the result register.
// Input stalls only on a high CRC byte while a finished result waits and the
//   output is stalled; every other byte keeps flowing.
// Reset (rst, synchronous): parser hunts for a start byte, CRC at 0xFFFF,
//   no result pending. Payload window registers are not reset.
module mavlink_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output mfr_pkg::msg_kind_t msg_kind,
  output logic [23:0] msg_id,
  output logic        is_version_two,
  output logic [7:0]  vehicle_type,
  output logic [7:0]  autopilot_kind,
  output logic [7:0]  mode_flags,
  output logic signed [31:0] rel_altitude_mm,
  output logic [15:0] ack_command,
  output logic [7:0]  ack_result
);
  import mfr_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic        frame_is_v2, frame_is_v2_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [23:0] message_ident, message_ident_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  pay_win [0:WIN_BYTES-1];

  logic        in_accept;
  logic        win_write;
  logic [15:0] crc_step;
  logic [15:0] crc_final;
  logic        frame_ok;

  // Decoded result fields
  msg_kind_t   kind_d;
  logic [7:0]  vehicle_d, autopilot_d, base_d, ack_res_d;
  logic [31:0] alt_d;
  logic [15:0] ack_cmd_d;

  // Hold only the byte that could finish a frame while a result waits
  assign in_stall  = out_valid & out_stall & (phase == PH_CRCHI);
  assign in_accept = in_valid & ~in_stall;

  assign crc_step  = x25_update(running_crc, rx_byte);
  assign crc_final = x25_update(running_crc, extra_byte(message_ident));

  // Read a window byte, zero at or past the received length
  function automatic logic [7:0] pay(input logic [7:0] b, input logic [7:0] idx,
                                     input logic [7:0] len);
    return (idx < len) ? b : 8'h00;
  endfunction

  // Next parser state
  always_comb begin
    phase_next          = phase;
    frame_is_v2_next    = frame_is_v2;
    payload_length_next = payload_length;
    payload_index_next  = payload_index;
    crc_low_byte_next   = crc_low_byte;
    message_ident_next  = message_ident;
    running_crc_next    = running_crc;
    win_write           = 1'b0;
    frame_ok            = 1'b0;
    case (phase)
      PH_START: begin
        if (rx_byte == START_V1 || rx_byte == START_V2) begin
          frame_is_v2_next = (rx_byte == START_V2);
          running_crc_next = CRC_SEED;
          phase_next       = PH_LEN;
        end
      end
      PH_LEN: begin
        running_crc_next    = crc_step;
        payload_length_next = rx_byte;
        phase_next          = frame_is_v2 ? PH_INCOMPAT : PH_SEQ;
      end
      PH_INCOMPAT: begin
        running_crc_next = crc_step;
        phase_next       = (rx_byte == 8'h00) ? PH_COMPAT : PH_START;
      end
      PH_COMPAT: begin
        running_crc_next = crc_step;
        phase_next       = PH_SEQ;
      end
      PH_SEQ: begin
        running_crc_next = crc_step;
        phase_next       = PH_SYS;
      end
      PH_SYS: begin
        running_crc_next = crc_step;
        phase_next       = PH_COMP;
      end
      PH_COMP: begin
        running_crc_next = crc_step;
        phase_next       = PH_ID0;
      end
      PH_ID0: begin
        running_crc_next   = crc_step;
        message_ident_next = {16'h0000, rx_byte};
        payload_index_next = 8'h00;
        if (frame_is_v2) begin
          phase_next = PH_ID1;
        end else begin
          phase_next = (payload_length != 8'h00) ? PH_PAYLOAD : PH_CRCLO;
        end
      end
      PH_ID1: begin
        running_crc_next   = crc_step;
        message_ident_next = {message_ident[23:16], rx_byte, message_ident[7:0]};
        phase_next         = PH_ID2;
      end
      PH_ID2: begin
        running_crc_next   = crc_step;
        message_ident_next = {rx_byte, message_ident[15:0]};
        phase_next         = (payload_length != 8'h00) ? PH_PAYLOAD : PH_CRCLO;
      end
      PH_PAYLOAD: begin
        running_crc_next   = crc_step;
        win_write          = (payload_index < 8'(WIN_BYTES));
        payload_index_next = payload_index + 8'd1;
        if (payload_index_next >= payload_length) begin
          phase_next = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_low_byte_next = rx_byte;
        phase_next        = PH_CRCHI;
      end
      PH_CRCHI: begin
        frame_ok   = (crc_final == {rx_byte, crc_low_byte});
        phase_next = PH_START;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
  end

  // Decode the fields of a finished frame
  always_comb begin
    kind_d      = KIND_OTHER;
    vehicle_d   = 8'h00;
    autopilot_d = 8'h00;
    base_d      = 8'h00;
    alt_d       = 32'h0000_0000;
    ack_cmd_d   = 16'h0000;
    ack_res_d   = 8'h00;
    if (message_ident == ID_HEARTBEAT) begin
      kind_d      = KIND_HEARTBEAT;
      vehicle_d   = pay(pay_win[4], 8'd4, payload_length);
      autopilot_d = pay(pay_win[5], 8'd5, payload_length);
      base_d      = pay(pay_win[6], 8'd6, payload_length);
    end else if (message_ident == ID_GLOBAL_POS) begin
      kind_d = KIND_GLOBAL_POS;
      alt_d  = {pay(pay_win[19], 8'd19, payload_length),
                pay(pay_win[18], 8'd18, payload_length),
                pay(pay_win[17], 8'd17, payload_length),
                pay(pay_win[16], 8'd16, payload_length)};
    end else if (message_ident == ID_CMD_ACK) begin
      kind_d    = KIND_CMD_ACK;
      ack_cmd_d = {pay(pay_win[1], 8'd1, payload_length),
                   pay(pay_win[0], 8'd0, payload_length)};
      ack_res_d = pay(pay_win[2], 8'd2, payload_length);
    end
  end

  // Advance the parser on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      frame_is_v2    <= 1'b0;
      payload_length <= 8'h00;
      payload_index  <= 8'h00;
      crc_low_byte   <= 8'h00;
      message_ident  <= 24'h000000;
      running_crc    <= CRC_SEED;
    end else if (in_accept) begin
      phase          <= phase_next;
      frame_is_v2    <= frame_is_v2_next;
      payload_length <= payload_length_next;
      payload_index  <= payload_index_next;
      crc_low_byte   <= crc_low_byte_next;
      message_ident  <= message_ident_next;
      running_crc    <= running_crc_next;
    end
  end

  // Capture payload bytes that fall in the decode window
  always_ff @(posedge clk) begin
    if (in_accept && win_write) begin
      pay_win[payload_index[WIN_IDX_W-1:0]] <= rx_byte;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && frame_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_ok) begin
      msg_kind        <= kind_d;
      msg_id          <= message_ident;
      is_version_two  <= frame_is_v2;
      vehicle_type    <= vehicle_d;
      autopilot_kind  <= autopilot_d;
      mode_flags      <= base_d;
      rel_altitude_mm <= signed'(alt_d);
      ack_command     <= ack_cmd_d;
      ack_result      <= ack_res_d;
    end
  end

  // A new result only follows a high CRC byte
  a_result_after_crc: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !(phase == PH_CRCHI)) |=> !out_valid || $past(out_valid))
    else $error("result raised outside the CRC byte");

  // The parser always returns to hunting after the CRC
  a_crc_returns_start: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_CRCHI) |=> phase == PH_START)
    else $error("parser did not return to start after CRC");

  // Heartbeat results carry message id zero
  a_heartbeat_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_kind == KIND_HEARTBEAT) |-> msg_id == ID_HEARTBEAT)
    else $error("heartbeat kind with nonzero id");

  // A v1 result never carries a wide message id
  a_v1_id_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_version_two) |-> msg_id[23:8] == 16'h0000)
    else $error("v1 frame with wide message id");

endmodule
